// File: hdl/csbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csbb_pkg
// Shared types and constants of the clipped sprite blitter.
// ----------------------------------------------------------------------------
package csbb_pkg;

    localparam int CSBB_MAX_SIDE = 4096;
    localparam int CSBB_QDEPTH   = 4;

    localparam int DIM_W      = 13;
    localparam int COLOR_W    = 8;
    localparam int ADDR_W     = 24;
    localparam int KEY_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [COLOR_W-1:0] NIBBLE_MASK = 8'hF0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_OFFSET_X   = 3'd4,
        REG_OFFSET_Y   = 3'd5,
        REG_BLEND_MODE = 3'd6,
        REG_KEY_COLOR  = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_COPY       = 2'd0,
        MODE_AVERAGE    = 2'd1,
        MODE_KEY_EXACT  = 2'd2,
        MODE_KEY_NIBBLE = 2'd3
    } t_mode;

    // what the back end writes for one pixel
    typedef enum logic [1:0] {
        OP_SOURCE  = 2'd0,
        OP_UNDER   = 2'd1,
        OP_AVERAGE = 2'd2
    } t_op;

    typedef struct packed {
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
        logic [DIM_W-1:0] dst_width;
        logic [DIM_W-1:0] dst_height;
        logic [DIM_W-1:0] offset_x;
        logic [DIM_W-1:0] offset_y;
        t_mode            blend_mode;
        logic [KEY_W-1:0] key_color;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic             in_bounds;
        logic             last;
        t_op              op;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        t_rgb             src;
        t_rgb             under;
    } t_job;

endpackage
`default_nettype wire

// File: hdl/clipped_sprite_blit_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_sprite_blit_blend
// Color-keyed sprite blitter with clipping against the destination surface.
// ----------------------------------------------------------------------------
// Source pixels enter in raster order on the i_valid / o_ready channel, each
// word carrying the source color and the destination color under it. Results
// leave on the o_valid / i_ready channel: write enable, destination address,
// blended color and a flag on the last pixel of the sprite.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
// by the user while no words are in flight; the block does not enforce it.
// Throughput is one word per cycle when the output does not stall. An
// accepted word is written into the queue, then moved into the row times
// width multiply stage and then loaded through the address add and blend
// into the output register.
// Reset loads the register defaults (sizes 1, the rest 0), clears the raster
// counters and empties the pipeline. When the receiver stalls, the output
// register holds, the two back stages and the four-entry queue fill, and
// o_ready then falls until space frees up.
// ----------------------------------------------------------------------------
module clipped_sprite_blit_blend
    import csbb_pkg::*;
#(
    parameter int MAX_SIDE = CSBB_MAX_SIDE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [COLOR_W-1:0]    i_src_red,
    input  wire logic [COLOR_W-1:0]    i_src_green,
    input  wire logic [COLOR_W-1:0]    i_src_blue,
    input  wire logic [COLOR_W-1:0]    i_under_red,
    input  wire logic [COLOR_W-1:0]    i_under_green,
    input  wire logic [COLOR_W-1:0]    i_under_blue,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_write_enable,
    output logic [ADDR_W-1:0]          o_dest_address,
    output logic [COLOR_W-1:0]         o_out_red,
    output logic [COLOR_W-1:0]         o_out_green,
    output logic [COLOR_W-1:0]         o_out_blue,
    output logic                       o_frame_last
);

    t_cfg r_cfg;
    t_rgb w_src, w_under, w_color;
    t_job w_push_job, w_pop_job;
    logic w_push, w_pop, w_q_full, w_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{src_width:  DIM_W'(1),
                       src_height: DIM_W'(1),
                       dst_width:  DIM_W'(1),
                       dst_height: DIM_W'(1),
                       offset_x:   '0,
                       offset_y:   '0,
                       blend_mode: MODE_COPY,
                       key_color:  '0};
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_wdata[DIM_W-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_wdata[DIM_W-1:0];
                REG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_wdata[DIM_W-1:0];
                REG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_wdata[DIM_W-1:0];
                REG_OFFSET_X:   r_cfg.offset_x   <= i_cfg_wdata[DIM_W-1:0];
                REG_OFFSET_Y:   r_cfg.offset_y   <= i_cfg_wdata[DIM_W-1:0];
                REG_BLEND_MODE: r_cfg.blend_mode <= t_mode'(i_cfg_wdata[1:0]);
                REG_KEY_COLOR:  r_cfg.key_color  <= i_cfg_wdata[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_src   = '{red: i_src_red, green: i_src_green, blue: i_src_blue};
    assign w_under = '{red: i_under_red, green: i_under_green, blue: i_under_blue};

    csbb_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_src    (w_src),
        .i_under  (w_under),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    csbb_queue #(
        .WIDTH ($bits(t_job)),
        .DEPTH (CSBB_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_q_empty)
    );

    csbb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dst_width    (r_cfg.dst_width),
        .i_q_empty      (w_q_empty),
        .o_pop          (w_pop),
        .i_job          (w_pop_job),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_dest_address (o_dest_address),
        .o_color        (w_color),
        .o_frame_last   (o_frame_last)
    );

    assign o_out_red   = w_color.red;
    assign o_out_green = w_color.green;
    assign o_out_blue  = w_color.blue;

endmodule
`default_nettype wire

// File: hdl/csbb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csbb_front
// Raster counters, clipping and blend classification of incoming pixels.
// ----------------------------------------------------------------------------
module csbb_front
    import csbb_pkg::*;
#(
    parameter int MAX_SIDE = CSBB_MAX_SIDE
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_rgb i_src,
    input  wire t_rgb i_under,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int PW = SW + 1;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;

    logic [SW-1:0] w_sw, w_sh, w_col_inc, w_row_inc;
    logic          w_last_col, w_last_row;
    logic signed [PW-1:0] w_px, w_py;
    logic          w_inside, w_key_exact, w_key_nibble, w_accept;
    t_rgb          w_key;
    t_op           w_op;

    // source size: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        w_sw = SW'(i_cfg.src_width);
        if (w_sw == '0) begin
            w_sw = SW'(1);
        end else if (w_sw > SW'(MAX_SIDE)) begin
            w_sw = SW'(MAX_SIDE);
        end
        w_sh = SW'(i_cfg.src_height);
        if (w_sh == '0) begin
            w_sh = SW'(1);
        end else if (w_sh > SW'(MAX_SIDE)) begin
            w_sh = SW'(MAX_SIDE);
        end
    end

    assign w_col_inc  = SW'(r_col) + SW'(1);
    assign w_row_inc  = SW'(r_row) + SW'(1);
    assign w_last_col = (w_col_inc >= w_sw);
    assign w_last_row = (w_row_inc >= w_sh);

    assign w_px = PW'($signed(i_cfg.offset_x)) + PW'($signed({1'b0, r_col}));
    assign w_py = PW'($signed(i_cfg.offset_y)) + PW'($signed({1'b0, r_row}));

    assign w_inside = !w_px[PW-1] && !w_py[PW-1]
                   && (w_px[PW-2:0] < (PW-1)'(i_cfg.dst_width))
                   && (w_py[PW-2:0] < (PW-1)'(i_cfg.dst_height));

    assign w_key = i_cfg.key_color;

    assign w_key_exact = (i_src == w_key);
    assign w_key_nibble = ((i_src.red & NIBBLE_MASK) == (w_key.red & NIBBLE_MASK))
                       && ((i_src.green & NIBBLE_MASK) == (w_key.green & NIBBLE_MASK))
                       && ((i_src.blue & NIBBLE_MASK) == (w_key.blue & NIBBLE_MASK));

    always_comb begin
        unique case (i_cfg.blend_mode)
            MODE_AVERAGE:    w_op = OP_AVERAGE;
            MODE_KEY_EXACT:  w_op = w_key_exact ? OP_UNDER : OP_SOURCE;
            MODE_KEY_NIBBLE: w_op = w_key_nibble ? OP_UNDER : OP_SOURCE;
            default:         w_op = OP_SOURCE;
        endcase
    end

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign o_push   = w_accept;

    always_comb begin
        o_job           = '0;
        o_job.in_bounds = w_inside;
        o_job.last      = w_last_col && w_last_row;
        o_job.op        = w_op;
        o_job.col       = w_px[DIM_W-1:0];
        o_job.row       = w_py[DIM_W-1:0];
        o_job.src       = i_src;
        o_job.under     = i_under;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_accept) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : w_row_inc[CW-1:0];
            end else begin
                n_col = w_col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire

// File: hdl/csbb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csbb_queue
// Small register queue between the front and the back of the blitter.
// ----------------------------------------------------------------------------
module csbb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_do_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd <= r_rd + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: hdl/csbb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csbb_back
// Address multiply, color blend and output register of the blitter.
// ----------------------------------------------------------------------------
module csbb_back
    import csbb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [DIM_W-1:0] i_dst_width,
    input  wire logic             i_q_empty,
    output logic                  o_pop,
    input  wire t_job             i_job,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_write_enable,
    output logic     [ADDR_W-1:0] o_dest_address,
    output t_rgb                  o_color,
    output logic                  o_frame_last
);

    function automatic logic [COLOR_W-1:0] blend(input t_op op,
                                                 input logic [COLOR_W-1:0] s,
                                                 input logic [COLOR_W-1:0] d);
        logic [COLOR_W:0] sum;
        logic [COLOR_W-1:0] res;
        sum = {1'b0, s} + {1'b0, d} + (COLOR_W+1)'(1);
        case (op)
            OP_AVERAGE: res = sum[COLOR_W:1];
            OP_UNDER:   res = d;
            default:    res = s;
        endcase
        return res;
    endfunction

    logic                r_s1_v;
    t_job                r_s1_job;
    logic [ADDR_W-1:0]   r_s1_prod;
    logic [2*DIM_W-1:0]  w_prod;
    logic                w_s1_open, w_s2_open;
    logic [ADDR_W-1:0]   w_addr;
    t_rgb                w_color;

    assign w_s2_open = !o_valid || i_ready;
    assign w_s1_open = !r_s1_v || w_s2_open;
    assign o_pop     = w_s1_open && !i_q_empty;

    assign w_prod = i_job.row * i_dst_width;
    assign w_addr = r_s1_prod + ADDR_W'(r_s1_job.col);

    always_comb begin
        w_color.red   = blend(r_s1_job.op, r_s1_job.src.red,   r_s1_job.under.red);
        w_color.green = blend(r_s1_job.op, r_s1_job.src.green, r_s1_job.under.green);
        w_color.blue  = blend(r_s1_job.op, r_s1_job.src.blue,  r_s1_job.under.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (w_s1_open) begin
                r_s1_v <= !i_q_empty;
            end
            if (w_s2_open) begin
                o_valid <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_open) begin
            r_s1_job  <= i_job;
            r_s1_prod <= w_prod[ADDR_W-1:0];
        end
        if (w_s2_open) begin
            o_write_enable <= r_s1_job.in_bounds;
            o_frame_last   <= r_s1_job.last;
            // clipped pixels carry zero address and color
            o_dest_address <= r_s1_job.in_bounds ? w_addr : '0;
            o_color        <= r_s1_job.in_bounds ? w_color : '0;
        end
    end

endmodule
`default_nettype wire

// File: hdl/csbb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csbb_checker
// Port-level checks of the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module csbb_checker
    import csbb_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic               o_write_enable,
    input wire logic [ADDR_W-1:0]  o_dest_address,
    input wire logic [COLOR_W-1:0] o_out_red,
    input wire logic [COLOR_W-1:0] o_out_green,
    input wire logic [COLOR_W-1:0] o_out_blue,
    input wire logic               o_frame_last
);

    // queue plus the two back stages
    localparam int CAP = CSBB_QDEPTH + 2;
    localparam int PCW = $clog2(CAP + 1);

    logic [PCW-1:0] r_pending;
    logic           w_in, w_out;

    assign w_in  = i_valid && o_ready;
    assign w_out = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in && !w_out) begin
            r_pending <= r_pending + PCW'(1);
        end else if (w_out && !w_in) begin
            r_pending <= r_pending - PCW'(1);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_write_enable, o_dest_address,
            o_out_red, o_out_green, o_out_blue, o_frame_last}))
        else $error("stalled output word changed");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_enable |-> o_dest_address == '0 && o_out_red == '0
            && o_out_green == '0 && o_out_blue == '0)
        else $error("clipped word carries nonzero address or color");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != '0)
        else $error("output word without a pending input word");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_pending < PCW'(CAP))
        else $error("input ready with the pipeline full");

endmodule

bind clipped_sprite_blit_blend csbb_checker u_csbb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_write_enable (o_write_enable),
    .o_dest_address (o_dest_address),
    .o_out_red      (o_out_red),
    .o_out_green    (o_out_green),
    .o_out_blue     (o_out_blue),
    .o_frame_last   (o_frame_last)
);
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for clipped_sprite_blit_blend.
// ----------------------------------------------------------------------------
// Source pixels are offered on the input channel and the written words are
// checked field by field against a local model of the raster counters,
// clipping, address and blend. A short directed table runs first: every
// blend mode, clipping on each side, odd register values and a size
// register lowered mid-frame. Random phases follow. Each phase reprograms
// every register and uses its own sender and receiver idling. Two phases
// open with a long receiver hold-off so that the block fills and stalls.
// ----------------------------------------------------------------------------
module tb;
    import csbb_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 8;
    localparam int PHASE_PIXELS = 50;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        t_rgb               color;
        logic               last;
    } t_pixel_write;

    typedef struct {
        bit                    is_reg;
        t_reg_idx              idx;
        logic [CFG_DATA_W-1:0] val;
        t_rgb                  src;
        t_rgb                  under;
        bit                    typed;
        t_pixel_write          want;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_valid;
    logic                  o_ready;
    logic [COLOR_W-1:0]    i_src_red, i_src_green, i_src_blue;
    logic [COLOR_W-1:0]    i_under_red, i_under_green, i_under_blue;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_write_enable;
    logic [ADDR_W-1:0]     o_dest_address;
    logic [COLOR_W-1:0]    o_out_red, o_out_green, o_out_blue;
    logic                  o_frame_last;

    // local copy of the register file and raster position
    t_cfg         blit_regs;
    int           src_col;
    int           src_row;
    t_pixel_write pending_writes[$];
    t_pixel_write head_write;
    int           mismatches = 0;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;
    int hold_served     = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;

    int send_idle_pcts[4]  = '{0, 46, 0, 24};
    int recv_stall_pcts[4] = '{0, 0, 46, 24};

    clipped_sprite_blit_blend dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_src_red      (i_src_red),
        .i_src_green    (i_src_green),
        .i_src_blue     (i_src_blue),
        .i_under_red    (i_under_red),
        .i_under_green  (i_under_green),
        .i_under_blue   (i_under_blue),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_dest_address (o_dest_address),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_frame_last   (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int side_len(logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > CSBB_MAX_SIDE) return CSBB_MAX_SIDE;
        return int'(v);
    endfunction

    // expected write for one source pixel; steps the raster counters
    function automatic t_pixel_write blit_predict(t_rgb src, t_rgb under);
        int               sw, sh, px, py;
        bit               last_col, last_row, keyed, in_bounds;
        logic [KEY_W-1:0] sbits;
        logic [47:0]      addr;
        t_rgb             mix;
        t_pixel_write     w;
        sw       = side_len(blit_regs.src_width);
        sh       = side_len(blit_regs.src_height);
        last_col = src_col + 1 >= sw;
        last_row = src_row + 1 >= sh;
        px       = int'($signed(blit_regs.offset_x)) + src_col;
        py       = int'($signed(blit_regs.offset_y)) + src_row;
        sbits    = src;
        keyed    = 1'b0;
        case (blit_regs.blend_mode)
            MODE_KEY_EXACT: keyed = sbits == blit_regs.key_color;
            MODE_KEY_NIBBLE: begin
                keyed = ((sbits ^ blit_regs.key_color) & {3{NIBBLE_MASK}}) == '0;
            end
            default: keyed = 1'b0;
        endcase
        if (blit_regs.blend_mode == MODE_AVERAGE) begin
            // rounds half up
            mix.red   = 8'((int'(src.red) + int'(under.red) + 1) / 2);
            mix.green = 8'((int'(src.green) + int'(under.green) + 1) / 2);
            mix.blue  = 8'((int'(src.blue) + int'(under.blue) + 1) / 2);
        end else begin
            mix = keyed ? under : src;
        end
        in_bounds = px >= 0 && py >= 0 && px < int'(blit_regs.dst_width)
                    && py < int'(blit_regs.dst_height);
        w      = '0;
        w.last = last_col && last_row;
        if (in_bounds) begin
            addr    = 48'(py) * 48'(blit_regs.dst_width) + 48'(px);
            w.we    = 1'b1;
            w.addr  = addr[ADDR_W-1:0];
            w.color = mix;
        end
        // a counter past a lowered size counts as the last position
        if (last_col) begin
            src_col = 0;
            src_row = last_row ? 0 : src_row + 1;
        end else begin
            src_col = src_col + 1;
        end
        return w;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
        end
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_SRC_WIDTH:  blit_regs.src_width  = val[DIM_W-1:0];
            REG_SRC_HEIGHT: blit_regs.src_height = val[DIM_W-1:0];
            REG_DST_WIDTH:  blit_regs.dst_width  = val[DIM_W-1:0];
            REG_DST_HEIGHT: blit_regs.dst_height = val[DIM_W-1:0];
            REG_OFFSET_X:   blit_regs.offset_x   = val[DIM_W-1:0];
            REG_OFFSET_Y:   blit_regs.offset_y   = val[DIM_W-1:0];
            REG_BLEND_MODE: blit_regs.blend_mode = t_mode'(val[1:0]);
            REG_KEY_COLOR:  blit_regs.key_color  = val[KEY_W-1:0];
        endcase
        @(posedge i_clk);
    endtask

    // stop offering and wait until every expected word has come back
    task automatic await_drain();
        i_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    task automatic offer_pixel(t_rgb src, t_rgb under, bit typed, t_pixel_write want);
        t_pixel_write w;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid     <= 1'b0;
            i_cfg_wr_en <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        i_valid     <= 1'b1;
        {i_src_red, i_src_green, i_src_blue}       <= src;
        {i_under_red, i_under_green, i_under_blue} <= under;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        w = blit_predict(src, under);
        pending_writes.push_back(typed ? want : w);
    endtask

    function automatic t_script_row blank_row();
        t_script_row r;
        r.is_reg = 1'b0;
        r.idx    = REG_SRC_WIDTH;
        r.val    = '0;
        r.src    = '0;
        r.under  = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_script_row reg_row(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        t_script_row r;
        r        = blank_row();
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic t_script_row pix_row(logic [23:0] src, logic [23:0] under);
        t_script_row r;
        r       = blank_row();
        r.src   = src;
        r.under = under;
        return r;
    endfunction

    function automatic t_script_row typed_row(logic [23:0] src, logic [23:0] under,
                                              logic we, logic [ADDR_W-1:0] addr,
                                              logic [23:0] color, logic last);
        t_script_row r;
        r       = pix_row(src, under);
        r.typed = 1'b1;
        r.want  = '{we: we, addr: addr, color: color, last: last};
        return r;
    endfunction

    task automatic run_script();
        t_script_row rows[$];
        // reset setup: 1x1 sprite on a 1x1 surface, plain copy
        rows.push_back(typed_row(24'hFF0080, 24'h123456, 1'b1, '0, 24'hFF0080, 1'b1));
        rows.push_back(typed_row(24'h00FF01, 24'hFFFFFF, 1'b1, '0, 24'h00FF01, 1'b1));
        rows.push_back(typed_row(24'h000000, 24'hFFFFFF, 1'b1, '0, 24'h000000, 1'b1));
        rows.push_back(reg_row(REG_BLEND_MODE, MODE_AVERAGE));
        rows.push_back(typed_row(24'hFFFFFF, 24'hFFFFFF, 1'b1, '0, 24'hFFFFFF, 1'b1));
        rows.push_back(typed_row(24'h000000, 24'h0100FF, 1'b1, '0, 24'h010080, 1'b1));
        rows.push_back(reg_row(REG_KEY_COLOR, 24'h123456));
        rows.push_back(reg_row(REG_BLEND_MODE, MODE_KEY_EXACT));
        rows.push_back(typed_row(24'h123456, 24'hAABBCC, 1'b1, '0, 24'hAABBCC, 1'b1));
        rows.push_back(typed_row(24'h123457, 24'hAABBCC, 1'b1, '0, 24'h123457, 1'b1));
        rows.push_back(reg_row(REG_KEY_COLOR, 24'hF0A050));
        rows.push_back(reg_row(REG_BLEND_MODE, MODE_KEY_NIBBLE));
        rows.push_back(typed_row(24'hFFAF5F, 24'h010203, 1'b1, '0, 24'h010203, 1'b1));
        rows.push_back(typed_row(24'hEFA050, 24'h010203, 1'b1, '0, 24'hEFA050, 1'b1));
        // clipped on the left, the bottom, then by a zero-width surface
        rows.push_back(reg_row(REG_BLEND_MODE, MODE_COPY));
        rows.push_back(reg_row(REG_OFFSET_X, 24'h001000));
        rows.push_back(typed_row(24'h808080, 24'h7F7F7F, 1'b0, '0, '0, 1'b1));
        rows.push_back(reg_row(REG_OFFSET_X, 24'h000000));
        rows.push_back(reg_row(REG_OFFSET_Y, 24'h000FFF));
        rows.push_back(typed_row(24'h808080, 24'h7F7F7F, 1'b0, '0, '0, 1'b1));
        rows.push_back(reg_row(REG_OFFSET_Y, 24'h000000));
        rows.push_back(reg_row(REG_DST_WIDTH, 24'h000000));
        rows.push_back(typed_row(24'h808080, 24'h7F7F7F, 1'b0, '0, '0, 1'b1));
        // 3x2 sprite hanging off the top-left corner of a 4x4 surface
        rows.push_back(reg_row(REG_DST_WIDTH, 24'd4));
        rows.push_back(reg_row(REG_DST_HEIGHT, 24'd4));
        rows.push_back(reg_row(REG_SRC_WIDTH, 24'd3));
        rows.push_back(reg_row(REG_SRC_HEIGHT, 24'd2));
        rows.push_back(reg_row(REG_OFFSET_X, 24'h001FFF));
        rows.push_back(reg_row(REG_OFFSET_Y, 24'h001FFF));
        for (int i = 0; i < 6; i++) begin
            rows.push_back(pix_row(24'(24'h10203 * (i + 1)), 24'hA5A5A5));
        end
        // width lowered below the column already reached
        rows.push_back(reg_row(REG_SRC_WIDTH, 24'd4));
        rows.push_back(pix_row(24'h0F0F0F, 24'hF0F0F0));
        rows.push_back(pix_row(24'hF0F0F0, 24'h0F0F0F));
        rows.push_back(reg_row(REG_SRC_WIDTH, 24'd1));
        rows.push_back(pix_row(24'h55AA55, 24'hAA55AA));
        rows.push_back(pix_row(24'hAA55AA, 24'h55AA55));
        // zero and oversized sides, oversized surface with a wrapping address
        rows.push_back(reg_row(REG_SRC_WIDTH, 24'h000000));
        rows.push_back(reg_row(REG_SRC_HEIGHT, 24'h001FFF));
        rows.push_back(reg_row(REG_DST_WIDTH, 24'h001FFF));
        rows.push_back(reg_row(REG_DST_HEIGHT, 24'h001FFF));
        rows.push_back(reg_row(REG_OFFSET_X, 24'h000FFF));
        rows.push_back(reg_row(REG_OFFSET_Y, 24'h000FFF));
        rows.push_back(pix_row(24'hC3C3C3, 24'h3C3C3C));
        rows.push_back(pix_row(24'h3C3C3C, 24'hC3C3C3));
        rows.push_back(reg_row(REG_SRC_HEIGHT, 24'h000000));
        rows.push_back(pix_row(24'h5A5A5A, 24'hA5A5A5));

        foreach (rows[i]) begin
            if (rows[i].is_reg) begin
                await_drain();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                offer_pixel(rows[i].src, rows[i].under, rows[i].typed, rows[i].want);
            end
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_src_side();
        int r;
        r = $urandom_range(19);
        if (r < 16) return CFG_DATA_W'($urandom_range(1, 6));
        if (r < 18) return {11'($urandom), 13'd0};
        if (r < 19) return CFG_DATA_W'(CSBB_MAX_SIDE);
        return {11'($urandom), 13'h1FFF};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dst_side();
        int r;
        r = $urandom_range(9);
        if (r < 8) return CFG_DATA_W'($urandom_range(1, 8));
        if (r < 9) return {11'($urandom), 13'd0};
        return CFG_DATA_W'($urandom_range(4097, 8191));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        int r;
        r = $urandom_range(19);
        if (r < 14) return {11'($urandom), 13'($urandom_range(9)) - 13'd3};
        if (r < 17) return CFG_DATA_W'($urandom);
        if (r < 18) return 24'h001000;
        return 24'h000FFF;
    endfunction

    // source colors lean toward the key so both key modes hit often
    function automatic t_rgb pick_source();
        case ($urandom_range(3))
            0: return blit_regs.key_color;
            1: return (blit_regs.key_color & {3{NIBBLE_MASK}})
                      | (24'($urandom) & ~{3{NIBBLE_MASK}});
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic program_phase();
        await_drain();
        write_reg(REG_SRC_WIDTH, pick_src_side());
        write_reg(REG_SRC_HEIGHT, pick_src_side());
        write_reg(REG_DST_WIDTH, pick_dst_side());
        write_reg(REG_DST_HEIGHT, pick_dst_side());
        write_reg(REG_OFFSET_X, pick_offset());
        write_reg(REG_OFFSET_Y, pick_offset());
        write_reg(REG_BLEND_MODE, {22'($urandom), 2'($urandom)});
        write_reg(REG_KEY_COLOR, 24'($urandom));
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // check each word that leaves against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (pending_writes.size() == 0) begin
                flag_mismatch("unexpected word, address", o_dest_address, 0);
            end else begin
                head_write = pending_writes.pop_front();
                if (o_write_enable !== head_write.we)
                    flag_mismatch("write_enable", o_write_enable, head_write.we);
                if (o_dest_address !== head_write.addr)
                    flag_mismatch("dest_address", o_dest_address, head_write.addr);
                if (o_out_red !== head_write.color.red)
                    flag_mismatch("out_red", o_out_red, head_write.color.red);
                if (o_out_green !== head_write.color.green)
                    flag_mismatch("out_green", o_out_green, head_write.color.green);
                if (o_out_blue !== head_write.color.blue)
                    flag_mismatch("out_blue", o_out_blue, head_write.color.blue);
                if (o_frame_last !== head_write.last)
                    flag_mismatch("frame_last", o_frame_last, head_write.last);
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= REG_SRC_WIDTH;
        i_cfg_wdata   <= '0;
        i_src_red     <= '0;
        i_src_green   <= '0;
        i_src_blue    <= '0;
        i_under_red   <= '0;
        i_under_green <= '0;
        i_under_blue  <= '0;
        blit_regs.src_width  = 13'd1;
        blit_regs.src_height = 13'd1;
        blit_regs.dst_width  = 13'd1;
        blit_regs.dst_height = 13'd1;
        blit_regs.offset_x   = '0;
        blit_regs.offset_y   = '0;
        blit_regs.blend_mode = MODE_COPY;
        blit_regs.key_color  = '0;
        src_col = 0;
        src_row = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_script();

        for (int p = 0; p < PHASES; p++) begin
            program_phase();
            sender_idle_pct = send_idle_pcts[p % 4];
            recv_stall_pct  = recv_stall_pcts[p % 4];
            if (p == 2 || p == 6) hold_requests++;
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                offer_pixel(pick_source(), 24'($urandom), 1'b0, '0);
            end
        end

        await_drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
